// ----- sv/ado_pkg.sv -----
`default_nettype none

package ado_pkg;

  // fixed-point and frame geometry
  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM   = 4096;

  // field widths
  localparam int PIX_W   = 12;
  localparam int CH_W    = 8;
  localparam int POS_W   = 21;
  localparam int RAD_W   = 20;
  localparam int COLOR_W = 3 * CH_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_COLOR  = 2'd3;

  // pixel index mask
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'(MAX_DIM - 1);

  // offset datapath
  localparam int SHIFT_W = PIX_W + FRAC_BITS;
  localparam int DX_W    = ((SHIFT_W + 1 > POS_W) ? SHIFT_W + 1 : POS_W) + 1;
  localparam int FAR_W   = 21;

  // square root datapath, radicand padded to an even width
  localparam int SQ_W   = 2 * FAR_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // coverage and blend
  localparam int REACH_W = RAD_W + 1;
  localparam int CMP_W   = ROOT_W + 1;
  localparam int A_W     = FRAC_BITS + 1;
  localparam int MIX_W   = A_W + CH_W + 1;

  localparam logic [A_W-1:0]     ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [REACH_W-1:0] HALF_FX = {{(REACH_W - FRAC_BITS){1'b0}}, 1'b1,
                                            {(FRAC_BITS - 1){1'b0}}};

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic signed [POS_W-1:0] center_col;
    logic signed [POS_W-1:0] center_row;
    logic [RAD_W-1:0]        disc_radius;
    logic [COLOR_W-1:0]      disc_color;
  } cfg_t;

  // per-pixel data riding along the pipeline
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            far;
  } side_t;

  // finished pixel
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            covered;
  } pix_out_t;

endpackage

`default_nettype wire

// ----- sv/ado_pix_if.sv -----
`default_nettype none

interface ado_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ado_pkg::PIX_W-1:0] pix_col;
  logic [ado_pkg::PIX_W-1:0] pix_row;
  logic [ado_pkg::CH_W-1:0]  red_in;
  logic [ado_pkg::CH_W-1:0]  green_in;
  logic [ado_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, pix_col, pix_row, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, pix_col, pix_row, red_in, green_in, blue_in,
                output ready);
endinterface

`default_nettype wire

// ----- sv/ado_res_if.sv -----
`default_nettype none

interface ado_res_if;
  logic                      valid;
  logic                      ready;
  logic [ado_pkg::CH_W-1:0] red_out;
  logic [ado_pkg::CH_W-1:0] green_out;
  logic [ado_pkg::CH_W-1:0] blue_out;
  logic                      covered;

  modport source (output valid, red_out, green_out, blue_out, covered,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, covered,
                output ready);
endinterface

`default_nettype wire

// ----- sv/ado_cfg_if.sv -----
`default_nettype none

interface ado_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ado_pkg::CFG_IDX_W-1:0]  index;
  logic [ado_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/antialiased_disc_overlay.sv -----
// channel   dir  contents                                       transfer
// pixel     in   pix_col, pix_row, red_in, green_in, blue_in    valid && ready
// result    out  red_out, green_out, blue_out, covered          valid && ready
// cfg       in   index, data (center_col/row, radius, color)    valid && ready
//
// one pixel per cycle sustained while results are taken; 4 offset/square stages,
// one stage per root bit (22) in the square root pipeline, coverage, blend.
// rst is synchronous and clears all valid bits and the configuration registers.
// a stalled result freezes the whole pipeline in place; pixel.ready is low
// only while the output register holds a pixel that is not being taken.
// cfg.ready is always high.

`default_nettype none

module antialiased_disc_overlay (
  input  logic      clk,
  input  logic      rst,
  ado_pix_if.sink   pixel,
  ado_res_if.source result,
  ado_cfg_if.sink   cfg
);

  ado_pkg::cfg_t                regs;
  ado_pkg::side_t               in_side;
  logic                         en;

  logic                         dist_valid;
  logic [ado_pkg::SQ_W-1:0]     radicand;
  ado_pkg::side_t               dist_side;

  logic                         root_valid;
  logic [ado_pkg::ROOT_W-1:0]   root;
  ado_pkg::side_t               root_side;

  logic                         out_valid;
  ado_pkg::pix_out_t            out_pix;

  // pipeline advances unless the output register is stuck
  assign en          = !out_valid || result.ready;
  assign pixel.ready = en;

  always_comb begin
    in_side.red   = pixel.red_in;
    in_side.green = pixel.green_in;
    in_side.blue  = pixel.blue_in;
    in_side.far   = 1'b0;
  end

  // configuration registers
  ado_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // offsets, magnitudes, squares, sum
  ado_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pixel.valid),
    .pix_col    (pixel.pix_col),
    .pix_row    (pixel.pix_row),
    .in_side    (in_side),
    .center_col (regs.center_col),
    .center_row (regs.center_row),
    .out_valid  (dist_valid),
    .radicand   (radicand),
    .out_side   (dist_side)
  );

  // distance
  ado_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dist_valid),
    .radicand  (radicand),
    .in_side   (dist_side),
    .out_valid (root_valid),
    .root      (root),
    .out_side  (root_side)
  );

  // coverage and color mix
  ado_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (root_valid),
    .root        (root),
    .in_side     (root_side),
    .disc_radius (regs.disc_radius),
    .disc_color  (regs.disc_color),
    .out_valid   (out_valid),
    .result      (out_pix)
  );

  // result channel
  assign result.valid     = out_valid;
  assign result.red_out   = out_pix.red;
  assign result.green_out = out_pix.green;
  assign result.blue_out  = out_pix.blue;
  assign result.covered   = out_pix.covered;

endmodule

`default_nettype wire

// ----- sv/ado_cfg_regs.sv -----
`default_nettype none

module ado_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ado_cfg_if.sink       cfg,
  output ado_pkg::cfg_t regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ado_pkg::CFG_CENTER_COL: begin
          regs.center_col <= $signed(cfg.data[ado_pkg::POS_W-1:0]);
        end
        ado_pkg::CFG_CENTER_ROW: begin
          regs.center_row <= $signed(cfg.data[ado_pkg::POS_W-1:0]);
        end
        ado_pkg::CFG_DISC_RADIUS: begin
          regs.disc_radius <= cfg.data[ado_pkg::RAD_W-1:0];
        end
        ado_pkg::CFG_DISC_COLOR: begin
          regs.disc_color <= cfg.data[ado_pkg::COLOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/ado_dist.sv -----
`default_nettype none

module ado_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ado_pkg::PIX_W-1:0]         pix_col,
  input  logic [ado_pkg::PIX_W-1:0]         pix_row,
  input  ado_pkg::side_t                    in_side,
  input  logic signed [ado_pkg::POS_W-1:0]  center_col,
  input  logic signed [ado_pkg::POS_W-1:0]  center_row,
  output logic                              out_valid,
  output logic [ado_pkg::SQ_W-1:0]          radicand,
  output ado_pkg::side_t                    out_side
);

  logic [ado_pkg::SHIFT_W-1:0]      col_fx;
  logic [ado_pkg::SHIFT_W-1:0]      row_fx;
  logic signed [ado_pkg::DX_W-1:0]  dx_next;
  logic signed [ado_pkg::DX_W-1:0]  dy_next;

  logic                             v1;
  logic signed [ado_pkg::DX_W-1:0]  dx1;
  logic signed [ado_pkg::DX_W-1:0]  dy1;
  ado_pkg::side_t                   side1;

  logic [ado_pkg::DX_W-1:0]         mag_x;
  logic [ado_pkg::DX_W-1:0]         mag_y;
  logic                             far_next;

  logic                             v2;
  logic [ado_pkg::FAR_W-1:0]        ax2;
  logic [ado_pkg::FAR_W-1:0]        ay2;
  ado_pkg::side_t                   side2;

  logic [2*ado_pkg::FAR_W-1:0]      sqx_next;
  logic [2*ado_pkg::FAR_W-1:0]      sqy_next;

  logic                             v3;
  logic [2*ado_pkg::FAR_W-1:0]      sqx3;
  logic [2*ado_pkg::FAR_W-1:0]      sqy3;
  ado_pkg::side_t                   side3;

  // offsets from the centre in fixed point
  assign col_fx  = {pix_col & ado_pkg::PIX_MASK, {ado_pkg::FRAC_BITS{1'b0}}};
  assign row_fx  = {pix_row & ado_pkg::PIX_MASK, {ado_pkg::FRAC_BITS{1'b0}}};
  assign dx_next = $signed({{(ado_pkg::DX_W - ado_pkg::SHIFT_W){1'b0}}, col_fx})
                 - $signed({{(ado_pkg::DX_W - ado_pkg::POS_W){center_col[ado_pkg::POS_W-1]}},
                            center_col});
  assign dy_next = $signed({{(ado_pkg::DX_W - ado_pkg::SHIFT_W){1'b0}}, row_fx})
                 - $signed({{(ado_pkg::DX_W - ado_pkg::POS_W){center_row[ado_pkg::POS_W-1]}},
                            center_row});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= dx_next;
      dy1   <= dy_next;
      side1 <= in_side;
    end
  end

  // magnitudes and far-pixel test
  assign mag_x    = dx1[ado_pkg::DX_W-1] ? (~dx1 + 1'b1) : dx1;
  assign mag_y    = dy1[ado_pkg::DX_W-1] ? (~dy1 + 1'b1) : dy1;
  assign far_next = (|mag_x[ado_pkg::DX_W-1:ado_pkg::FAR_W])
                 || (|mag_y[ado_pkg::DX_W-1:ado_pkg::FAR_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2   <= far_next ? '0 : mag_x[ado_pkg::FAR_W-1:0];
      ay2   <= far_next ? '0 : mag_y[ado_pkg::FAR_W-1:0];
      side2 <= '{red: side1.red, green: side1.green, blue: side1.blue, far: far_next};
    end
  end

  // squares
  assign sqx_next = {{ado_pkg::FAR_W{1'b0}}, ax2} * {{ado_pkg::FAR_W{1'b0}}, ax2};
  assign sqy_next = {{ado_pkg::FAR_W{1'b0}}, ay2} * {{ado_pkg::FAR_W{1'b0}}, ay2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3  <= sqx_next;
      sqy3  <= sqy_next;
      side3 <= side2;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radicand <= {2'b00, sqx3} + {2'b00, sqy3};
      out_side <= side3;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ado_isqrt.sv -----
`default_nettype none

module ado_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ado_pkg::SQ_W-1:0]    radicand,
  input  ado_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [ado_pkg::ROOT_W-1:0]  root,
  output ado_pkg::side_t              out_side
);

  // one result bit per stage
  logic                        valid_q [ado_pkg::ROOT_W];
  ado_pkg::side_t              side_q  [ado_pkg::ROOT_W];
  logic [ado_pkg::ROOT_W-1:0]  root_q  [ado_pkg::ROOT_W];
  logic [ado_pkg::REM_W-1:0]   rem_q   [ado_pkg::ROOT_W-1];
  logic [ado_pkg::SQ_W-1:0]    n_q     [ado_pkg::ROOT_W-1];

  for (genvar k = 0; k < ado_pkg::ROOT_W; k++) begin : g_step
    logic                        valid_in;
    ado_pkg::side_t              side_in;
    logic [ado_pkg::ROOT_W-1:0]  root_in;
    logic [ado_pkg::REM_W-1:0]   rem_in;
    logic [ado_pkg::SQ_W-1:0]    n_in;
    logic [ado_pkg::REM_W-1:0]   rem_sh;
    logic [ado_pkg::REM_W-1:0]   trial;
    logic                        fits;

    // stage source
    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign side_in  = in_side;
      assign root_in  = '0;
      assign rem_in   = '0;
      assign n_in     = radicand;
    end else begin : g_mid
      assign valid_in = valid_q[k-1];
      assign side_in  = side_q[k-1];
      assign root_in  = root_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign n_in     = n_q[k-1];
    end

    // bring down two bits and try the next root bit
    assign rem_sh = {rem_in[ado_pkg::REM_W-3:0], n_in[ado_pkg::SQ_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= side_in;
        root_q[k] <= {root_in[ado_pkg::ROOT_W-2:0], fits};
      end
    end

    // remainder and radicand are not needed past the last step
    if (k < ado_pkg::ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= fits ? (rem_sh - trial) : rem_sh;
          n_q[k]   <= {n_in[ado_pkg::SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = valid_q[ado_pkg::ROOT_W-1];
  assign root      = root_q[ado_pkg::ROOT_W-1];
  assign out_side  = side_q[ado_pkg::ROOT_W-1];

endmodule

`default_nettype wire

// ----- sv/ado_blend.sv -----
`default_nettype none

module ado_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ado_pkg::ROOT_W-1:0]  root,
  input  ado_pkg::side_t              in_side,
  input  logic [ado_pkg::RAD_W-1:0]   disc_radius,
  input  logic [ado_pkg::COLOR_W-1:0] disc_color,
  output logic                        out_valid,
  output ado_pkg::pix_out_t           result
);

  logic [ado_pkg::REACH_W-1:0]  reach;
  logic [ado_pkg::CMP_W-1:0]    diff;
  logic                         inside_disc;
  logic                         saturate;
  logic [ado_pkg::A_W-1:0]      a_next;

  logic                         cov_valid;
  logic [ado_pkg::A_W-1:0]      cov_a;
  ado_pkg::side_t               cov_side;

  logic [ado_pkg::A_W-1:0]      inv_a;

  // ((one - a) * pixel + a * colour) >> frac, truncated
  function automatic logic [ado_pkg::CH_W-1:0] mix(
    input logic [ado_pkg::A_W-1:0]  a,
    input logic [ado_pkg::A_W-1:0]  inv,
    input logic [ado_pkg::CH_W-1:0] pix,
    input logic [ado_pkg::CH_W-1:0] col
  );
    logic [ado_pkg::MIX_W-1:0] acc;
    acc = {{(ado_pkg::CH_W + 1){1'b0}}, inv} * {{(ado_pkg::A_W + 1){1'b0}}, pix}
        + {{(ado_pkg::CH_W + 1){1'b0}}, a} * {{(ado_pkg::A_W + 1){1'b0}}, col};
    return acc[ado_pkg::FRAC_BITS +: ado_pkg::CH_W];
  endfunction

  // coverage: radius + 1/2 - distance, clamped to 0..1
  assign reach       = {1'b0, disc_radius} + ado_pkg::HALF_FX;
  assign diff        = {{(ado_pkg::CMP_W - ado_pkg::REACH_W){1'b0}}, reach}
                     - {{(ado_pkg::CMP_W - ado_pkg::ROOT_W){1'b0}}, root};
  assign inside_disc = !diff[ado_pkg::CMP_W-1] && (diff != '0) && !in_side.far;
  assign saturate    = diff > {{(ado_pkg::CMP_W - ado_pkg::A_W){1'b0}}, ado_pkg::ONE_FX};
  assign a_next      = !inside_disc ? '0
                     : saturate    ? ado_pkg::ONE_FX
                     : diff[ado_pkg::A_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cov_valid <= 1'b0;
    end else if (en) begin
      cov_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov_a    <= a_next;
      cov_side <= in_side;
    end
  end

  // per-channel blend into the output register
  assign inv_a = ado_pkg::ONE_FX - cov_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cov_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.red     <= mix(cov_a, inv_a, cov_side.red,
                            disc_color[2*ado_pkg::CH_W +: ado_pkg::CH_W]);
      result.green   <= mix(cov_a, inv_a, cov_side.green,
                            disc_color[ado_pkg::CH_W +: ado_pkg::CH_W]);
      result.blue    <= mix(cov_a, inv_a, cov_side.blue,
                            disc_color[0 +: ado_pkg::CH_W]);
      result.covered <= (cov_a != '0);
    end
  end

`ifndef SYNTHESIS
  // coverage never exceeds one
  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    cov_valid |-> (cov_a <= ado_pkg::ONE_FX))
    else $error("coverage above one");

  // far pixels are never covered
  a_far_clear: assert property (@(posedge clk) disable iff (rst)
    (cov_valid && cov_side.far) |-> (cov_a == '0))
    else $error("far pixel got coverage");

  // covered flag follows the coverage that produced it
  a_cov_flag: assert property (@(posedge clk) disable iff (rst)
    (en && cov_valid) |=> (out_valid && (result.covered == ($past(cov_a) != '0))))
    else $error("covered flag does not match coverage");

  // a stalled output neither drops nor creates a pixel
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (out_valid == $past(out_valid)))
    else $error("output valid changed during stall");
`endif

endmodule

`default_nettype wire
